>>> sv/v3a_pkg.sv
// Package for the vector3 ALU: operation codes, pipeline payload types and
// the 32-bit saturation helper. No dependencies.
package v3a_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ROOT_CELLS    = 32;

	localparam logic [2:0] OP_NEG   = 3'd0;
	localparam logic [2:0] OP_LEN   = 3'd1;
	localparam logic [2:0] OP_NORM  = 3'd2;
	localparam logic [2:0] OP_DOT   = 3'd3;
	localparam logic [2:0] OP_CROSS = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  sgn;
		logic [31:0] mx;
		logic [31:0] my;
		logic [31:0] mz;
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] rz;
		logic [1:0]  rw;
		logic [31:0] sc;
		logic        sat;
	} base_t;

	typedef struct packed {
		logic [63:0] s;
		logic [33:0] r;
		logic [31:0] q;
	} sqrt_t;

	typedef struct packed {
		logic [31:0] remx;
		logic [31:0] remy;
		logic [31:0] remz;
		logic [2:0]  nb;
		logic [31:0] qx;
		logic [31:0] qy;
		logic [31:0] qz;
	} div_t;

	function automatic logic [32:0] sat66(input logic signed [65:0] v);
		logic [32:0] res;
		if (v > $signed(66'h00000000007FFFFFFF))
			res = {1'b1, 32'h7FFFFFFF};
		else if (v < $signed(66'h3FFFFFFFF80000000))
			res = {1'b1, 32'h80000000};
		else
			res = {1'b0, v[31:0]};
		return res;
	endfunction

endpackage

>>> sv/v3a_front.sv
// Front stages of the vector3 ALU: multiply, sum, shift and saturate.
// Depends on v3a_pkg.
module v3a_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [1:0]  aw,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	output logic               out_valid,
	input  logic               out_ready,
	output v3a_pkg::base_t     out_base,
	output v3a_pkg::sqrt_t     out_sqrt
);
	import v3a_pkg::*;

	logic v1_q, v2_q, v3_q, rdy1, rdy2, rdy3;
	logic sq, cr;
	logic signed [31:0] m0a, m0b, m1a, m1b, m2a, m2b;
	logic [2:0] op_s1, op_s2;
	logic signed [31:0] ax_s1, ay_s1, az_s1, ax_s2, ay_s2, az_s2;
	logic signed [1:0] aw_s1, aw_s2;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic [2:0] aw2;
	logic [63:0] sq_s2;
	logic signed [65:0] dot_s2, cx_s2, cy_s2, cz_s2;
	logic signed [65:0] nx, ny, nz, dsh, xsh, ysh, zsh;
	logic [32:0] snx, sny, snz, sdot, scx, scy, scz;
	base_t b;

	assign rdy3 = !v3_q || out_ready;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v3_q;

	assign sq = (op == OP_LEN) || (op == OP_NORM);
	assign cr = (op == OP_CROSS);
	assign m0a = sq ? ax : (cr ? ay : ax);
	assign m0b = sq ? ax : (cr ? bz : bx);
	assign m1a = sq ? ay : (cr ? az : ay);
	assign m1b = sq ? ay : by;
	assign m2a = az;
	assign m2b = sq ? az : (cr ? bx : bz);

	always_comb begin
		case (aw_s1)
			2'b10:        aw2 = 3'd4;
			2'b01, 2'b11: aw2 = 3'd1;
			default:      aw2 = 3'd0;
		endcase
	end

	assign nx = -$signed({{34{ax_s2[31]}}, ax_s2});
	assign ny = -$signed({{34{ay_s2[31]}}, ay_s2});
	assign nz = -$signed({{34{az_s2[31]}}, az_s2});
	assign dsh = dot_s2 >>> FRAC_BITS;
	assign xsh = cx_s2 >>> FRAC_BITS;
	assign ysh = cy_s2 >>> FRAC_BITS;
	assign zsh = cz_s2 >>> FRAC_BITS;
	assign snx = sat66(nx);
	assign sny = sat66(ny);
	assign snz = sat66(nz);
	assign sdot = sat66(dsh);
	assign scx = sat66(xsh);
	assign scy = sat66(ysh);
	assign scz = sat66(zsh);

	always_comb begin
		b = '0;
		b.op = op_s2;
		b.sgn = {az_s2[31], ay_s2[31], ax_s2[31]};
		b.mx = ax_s2[31] ? 32'(-ax_s2) : 32'(ax_s2);
		b.my = ay_s2[31] ? 32'(-ay_s2) : 32'(ay_s2);
		b.mz = az_s2[31] ? 32'(-az_s2) : 32'(az_s2);
		case (op_s2)
			OP_NEG: begin
				b.rx = snx[31:0];
				b.ry = sny[31:0];
				b.rz = snz[31:0];
				b.rw = (aw_s2 == 2'b10) ? 2'b01 : 2'(-aw_s2);
				b.sat = snx[32] | sny[32] | snz[32] | (aw_s2 == 2'b10);
			end
			OP_DOT: begin
				b.sc = sdot[31:0];
				b.sat = sdot[32];
			end
			OP_CROSS: begin
				b.rx = scx[31:0];
				b.ry = scy[31:0];
				b.rz = scz[31:0];
				b.sat = scx[32] | scy[32] | scz[32];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			op_s1 <= op;
			ax_s1 <= ax;
			ay_s1 <= ay;
			az_s1 <= az;
			aw_s1 <= aw;
			p0_s1 <= m0a * m0b;
			p1_s1 <= m1a * m1b;
			p2_s1 <= m2a * m2b;
			p3_s1 <= ax * bz;
			p4_s1 <= ax * by;
			p5_s1 <= ay * bx;
		end
		if (v1_q && rdy2) begin
			op_s2 <= op_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			az_s2 <= az_s1;
			aw_s2 <= aw_s1;
			sq_s2 <= 64'(p0_s1) + 64'(p1_s1) + 64'(p2_s1)
				+ (64'(aw2) << (2 * FRAC_BITS));
			dot_s2 <= $signed({{2{p0_s1[63]}}, p0_s1}) + $signed({{2{p1_s1[63]}}, p1_s1})
				+ $signed({{2{p2_s1[63]}}, p2_s1});
			cx_s2 <= $signed({{2{p0_s1[63]}}, p0_s1}) - $signed({{2{p1_s1[63]}}, p1_s1});
			cy_s2 <= $signed({{2{p2_s1[63]}}, p2_s1}) - $signed({{2{p3_s1[63]}}, p3_s1});
			cz_s2 <= $signed({{2{p4_s1[63]}}, p4_s1}) - $signed({{2{p5_s1[63]}}, p5_s1});
		end
		if (v2_q && rdy3) begin
			out_base <= b;
			out_sqrt.s <= sq_s2;
			out_sqrt.r <= '0;
			out_sqrt.q <= '0;
		end
	end

endmodule

>>> sv/v3a_root_cell.sv
// One cell of the square root chain: one root bit per cell.
// Depends on v3a_pkg.
module v3a_root_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  v3a_pkg::base_t in_base,
	input  v3a_pkg::sqrt_t in_sqrt,
	output logic           out_valid,
	input  logic           out_ready,
	output v3a_pkg::base_t out_base,
	output v3a_pkg::sqrt_t out_sqrt
);
	import v3a_pkg::*;

	logic v_q;
	logic [35:0] rr, tt;
	sqrt_t nx;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign rr = {in_sqrt.r, in_sqrt.s[63:62]};
	assign tt = {2'b00, in_sqrt.q, 2'b01};

	always_comb begin
		nx.s = {in_sqrt.s[61:0], 2'b00};
		if (rr >= tt) begin
			nx.r = 34'(rr - tt);
			nx.q = {in_sqrt.q[30:0], 1'b1};
		end else begin
			nx.r = rr[33:0];
			nx.q = {in_sqrt.q[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_base <= in_base;
			out_sqrt <= nx;
		end
	end

endmodule

>>> sv/v3a_div_cell.sv
// One cell of the normalize divider chain: one quotient bit for x, y and z.
// Depends on v3a_pkg.
module v3a_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  v3a_pkg::base_t in_base,
	input  logic [31:0]    in_len,
	input  v3a_pkg::div_t  in_div,
	output logic           out_valid,
	input  logic           out_ready,
	output v3a_pkg::base_t out_base,
	output logic [31:0]    out_len,
	output v3a_pkg::div_t  out_div
);
	import v3a_pkg::*;

	logic v_q;
	logic [32:0] tx, ty, tz, d;
	div_t nx;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign d = {1'b0, in_len};
	assign tx = {in_div.remx, in_div.nb[0]};
	assign ty = {in_div.remy, in_div.nb[1]};
	assign tz = {in_div.remz, in_div.nb[2]};

	always_comb begin
		nx.nb = 3'b000;
		nx.remx = (tx >= d) ? 32'(tx - d) : tx[31:0];
		nx.remy = (ty >= d) ? 32'(ty - d) : ty[31:0];
		nx.remz = (tz >= d) ? 32'(tz - d) : tz[31:0];
		nx.qx = {in_div.qx[30:0], tx >= d};
		nx.qy = {in_div.qy[30:0], ty >= d};
		nx.qz = {in_div.qz[30:0], tz >= d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_base <= in_base;
			out_len <= in_len;
			out_div <= nx;
		end
	end

endmodule

>>> sv/vector3_alu.sv
// Top level of the vector3 ALU: front stages, root chain, divider chain and
// output register. Depends on v3a_pkg, v3a_front, v3a_root_cell, v3a_div_cell.
//
//   channel  dir  payload
//   s_*      in   tuser op; tdata ax ay az aw bx by bz
//   m_*      out  tuser saturated zero_length; tdata rx ry rz rw scalar
//
// One transfer per cycle sustained while m_tready stays high; items pass the front
// stages, the root chain (one bit per cell) and the divider chain.
// Every cell holds its item while the next cell is full and stalled.
// Reset empties all cells; data registers are not reset.
module vector3_alu #(
	parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [199:0] s_tdata,  // ax, ay, az, aw, bx, by, bz, zero pad
	input  logic [2:0]   s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // rx, ry, rz, rw, scalar, zero pad
	output logic [1:0]   m_tuser   // saturated, zero_length
);
	import v3a_pkg::*;

	localparam int DIV_CELLS = FRAC_BITS + 1;

	logic  rv [ROOT_CELLS+1];
	logic  rr [ROOT_CELLS+1];
	base_t rb [ROOT_CELLS+1];
	sqrt_t rs [ROOT_CELLS+1];
	logic        dv [DIV_CELLS+1];
	logic        dr [DIV_CELLS+1];
	base_t       db [DIV_CELLS+1];
	logic [31:0] dl [DIV_CELLS+1];
	div_t        dd [DIV_CELLS+1];

	logic out_rdy;
	base_t fb;
	logic [31:0] len;
	logic [31:0] rx_d, ry_d, rz_d, sc_d;
	logic sat_d, zl_d;
	logic [31:0] rx_q, ry_q, rz_q, sc_q;
	logic [1:0] rw_q;
	logic sat_q, zl_q;

	v3a_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tuser), .ax(s_tdata[31:0]), .ay(s_tdata[63:32]), .az(s_tdata[95:64]),
		.aw(s_tdata[97:96]), .bx(s_tdata[129:98]), .by(s_tdata[161:130]),
		.bz(s_tdata[193:162]),
		.out_valid(rv[0]), .out_ready(rr[0]), .out_base(rb[0]), .out_sqrt(rs[0])
	);

	for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
		v3a_root_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(rv[i]), .in_ready(rr[i]), .in_base(rb[i]), .in_sqrt(rs[i]),
			.out_valid(rv[i+1]), .out_ready(rr[i+1]), .out_base(rb[i+1]),
			.out_sqrt(rs[i+1])
		);
	end

	assign dv[0] = rv[ROOT_CELLS];
	assign rr[ROOT_CELLS] = dr[0];
	assign db[0] = rb[ROOT_CELLS];
	assign dl[0] = rs[ROOT_CELLS].q;
	assign dd[0].remx = {1'b0, rb[ROOT_CELLS].mx[31:1]};
	assign dd[0].remy = {1'b0, rb[ROOT_CELLS].my[31:1]};
	assign dd[0].remz = {1'b0, rb[ROOT_CELLS].mz[31:1]};
	assign dd[0].nb = {rb[ROOT_CELLS].mz[0], rb[ROOT_CELLS].my[0], rb[ROOT_CELLS].mx[0]};
	assign dd[0].qx = '0;
	assign dd[0].qy = '0;
	assign dd[0].qz = '0;

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		v3a_div_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(dv[j]), .in_ready(dr[j]), .in_base(db[j]), .in_len(dl[j]),
			.in_div(dd[j]),
			.out_valid(dv[j+1]), .out_ready(dr[j+1]), .out_base(db[j+1]),
			.out_len(dl[j+1]), .out_div(dd[j+1])
		);
	end

	assign out_rdy = !m_tvalid || m_tready;
	assign dr[DIV_CELLS] = out_rdy;
	assign fb = db[DIV_CELLS];
	assign len = dl[DIV_CELLS];

	always_comb begin
		rx_d = fb.rx;
		ry_d = fb.ry;
		rz_d = fb.rz;
		sc_d = fb.sc;
		sat_d = fb.sat;
		zl_d = 1'b0;
		case (fb.op)
			OP_LEN: begin
				sc_d = len[31] ? 32'h7FFFFFFF : len;
				sat_d = len[31];
			end
			OP_NORM: begin
				if (len == 32'd0) begin
					zl_d = 1'b1;
				end else begin
					rx_d = fb.sgn[0] ? -dd[DIV_CELLS].qx : dd[DIV_CELLS].qx;
					ry_d = fb.sgn[1] ? -dd[DIV_CELLS].qy : dd[DIV_CELLS].qy;
					rz_d = fb.sgn[2] ? -dd[DIV_CELLS].qz : dd[DIV_CELLS].qz;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_rdy) m_tvalid <= dv[DIV_CELLS];
	end

	always_ff @(posedge clk) begin
		if (dv[DIV_CELLS] && out_rdy) begin
			rx_q <= rx_d;
			ry_q <= ry_d;
			rz_q <= rz_d;
			rw_q <= fb.rw;
			sc_q <= sc_d;
			sat_q <= sat_d;
			zl_q <= zl_d;
		end
	end

	assign m_tdata = {6'd0, sc_q, rw_q, rz_q, ry_q, rx_q};
	assign m_tuser = {zl_q, sat_q};

`ifndef SYNTH
	a_zero_len_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && zl_q |-> rx_q == 32'd0 && ry_q == 32'd0 && rz_q == 32'd0
			&& sc_q == 32'd0)
		else $error("zero length result not cleared");
	a_flags_apart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(sat_q && zl_q))
		else $error("saturated and zero length both set");
	a_scalar_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sc_q != 32'd0 |-> rw_q == 2'd0)
		else $error("scalar result with nonzero tuple kind");
`endif

endmodule

>>> tb/sv/tb_vector3_checker.sv
// Checker for the vector3 ALU: watches both stream channels, predicts each
// result from the accepted operands and compares field by field.
// Depends on v3a_pkg for the operation codes.
module tb_vector3_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [199:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending,
	output int           results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import v3a_pkg::*;

	localparam int FRAC = 16;

	typedef struct packed {
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] rz;
		logic [1:0]  rw;
		logic [31:0] sc;
		logic        sat;
		logic        zl;
	} vec_result_t;

	vec_result_t expected_q[$];

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
	end

	function automatic logic [31:0] clip32(input logic signed [65:0] v, inout logic flag);
		if (v > 66'sd2147483647) begin
			flag = 1'b1;
			return 32'h7FFFFFFF;
		end
		if (v < -66'sd2147483648) begin
			flag = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] s);
		logic [63:0] rem, res, b;
		rem = s;
		res = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [65:0] scaled_quot(input logic signed [31:0] c,
			input logic [63:0] len);
		logic [63:0] mag, q;
		mag = (c < 0) ? 64'(-longint'(c)) : 64'(longint'(c));
		q = (mag << FRAC) / len;
		return (c < 0) ? -$signed({2'b0, q}) : $signed({2'b0, q});
	endfunction

	function automatic logic signed [65:0] prod(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [65:0] ea, eb;
		ea = a;
		eb = b;
		return ea * eb;
	endfunction

	function automatic vec_result_t compute_vector_op(input logic [2:0] op,
			input logic [199:0] d);
		vec_result_t r;
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic signed [1:0]  aw;
		logic signed [65:0] acc, w;
		logic [65:0] sumsq;
		logic [63:0] len;
		ax = d[31:0];
		ay = d[63:32];
		az = d[95:64];
		aw = d[97:96];
		bx = d[129:98];
		by = d[161:130];
		bz = d[193:162];
		r = '0;
		case (op)
			OP_NEG: begin
				r.rx = clip32(-$signed(66'(ax)), r.sat);
				r.ry = clip32(-$signed(66'(ay)), r.sat);
				r.rz = clip32(-$signed(66'(az)), r.sat);
				w = -$signed(66'(aw));
				if (w > 1) begin
					w = 1;
					r.sat = 1'b1;
				end
				r.rw = w[1:0];
			end
			OP_LEN, OP_NORM: begin
				sumsq = prod(ax, ax) + prod(ay, ay) + prod(az, az)
					+ (66'(prod(32'(aw), 32'(aw))) << (2 * FRAC));
				len = root_floor(sumsq[63:0]);
				if (op == OP_LEN) begin
					r.sc = clip32($signed({2'b0, len}), r.sat);
				end else if (len == 0) begin
					r.zl = 1'b1;
				end else begin
					r.rx = clip32(scaled_quot(ax, len), r.sat);
					r.ry = clip32(scaled_quot(ay, len), r.sat);
					r.rz = clip32(scaled_quot(az, len), r.sat);
				end
			end
			OP_DOT: begin
				acc = prod(ax, bx) + prod(ay, by) + prod(az, bz);
				r.sc = clip32(acc >>> FRAC, r.sat);
			end
			OP_CROSS: begin
				acc = prod(ay, bz) - prod(az, by);
				r.rx = clip32(acc >>> FRAC, r.sat);
				acc = prod(az, bx) - prod(ax, bz);
				r.ry = clip32(acc >>> FRAC, r.sat);
				acc = prod(ax, by) - prod(ay, bx);
				r.rz = clip32(acc >>> FRAC, r.sat);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%0t mismatch on result %0d: %s got %h want %h", $time, results_seen,
			what, got, want);
	endtask

	always @(posedge clk) begin
		vec_result_t exp_r, got_r;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_q.push_back(compute_vector_op(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got_r.rx = m_tdata[31:0];
				got_r.ry = m_tdata[63:32];
				got_r.rz = m_tdata[95:64];
				got_r.rw = m_tdata[97:96];
				got_r.sc = m_tdata[129:98];
				got_r.sat = m_tuser[0];
				got_r.zl = m_tuser[1];
				results_seen++;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected transfer", 0, 0);
				end else begin
					exp_r = expected_q.pop_front();
					if (got_r.rx !== exp_r.rx) report_mismatch("rx", got_r.rx, exp_r.rx);
					if (got_r.ry !== exp_r.ry) report_mismatch("ry", got_r.ry, exp_r.ry);
					if (got_r.rz !== exp_r.rz) report_mismatch("rz", got_r.rz, exp_r.rz);
					if (got_r.rw !== exp_r.rw) report_mismatch("rw", got_r.rw, exp_r.rw);
					if (got_r.sc !== exp_r.sc) report_mismatch("scalar", got_r.sc, exp_r.sc);
					if (got_r.sat !== exp_r.sat)
						report_mismatch("saturated", got_r.sat, exp_r.sat);
					if (got_r.zl !== exp_r.zl)
						report_mismatch("zero_length", got_r.zl, exp_r.zl);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the vector3 ALU: clock, reset, operand stimulus and
// result backpressure. Depends on v3a_pkg, vector3_alu and tb_vector3_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import v3a_pkg::*;

	localparam int N_RANDOM = 1000;
	localparam int DRAIN_CYCLES = 100;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [199:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic [1:0]   m_tuser;
	int           errors, pending, results_seen;
	int           op_count[8];
	bit           no_idle = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	vector3_alu u_top (.*);

	tb_vector3_checker u_chk (.*);

	initial begin
		#5ms;
		$display("timeout");
		$display("tb_top NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		int wait_left;
		if (!arst_n) begin
			m_tready <= 1'b0;
			wait_left = 0;
		end else begin
			if (m_tvalid && m_tready)
				wait_left = no_idle ? 0 : $urandom_range(0, 15);
			if (wait_left > 0) begin
				wait_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 32'($signed($urandom_range(0, 262143)) - 131072);
			3: return 32'($signed($urandom_range(0, 511)) - 256);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_operands(input logic [2:0] op, input logic [31:0] ax,
			input logic [31:0] ay, input logic [31:0] az, input logic [1:0] aw,
			input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, bz, by, bx, aw, az, ay, ax};
		do @(posedge clk); while (!s_tready);
		op_count[op]++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [2:0] op;
		int k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_operands(OP_NEG, 32'h80000000, 32'h7FFFFFFF, 32'h00010000, 2'b10, 0, 0, 0);
		send_operands(OP_NEG, 32'hFFFF0000, 0, 32'h80000001, 2'b01, 0, 0, 0);
		send_operands(OP_NEG, 1, 2, 3, 2'b11, 0, 0, 0);
		send_operands(OP_LEN, 0, 0, 0, 2'b00, 0, 0, 0);
		send_operands(OP_LEN, 32'h80000000, 32'h80000000, 32'h80000000, 2'b10, 0, 0, 0);
		send_operands(OP_LEN, 32'h00030000, 32'h00040000, 0, 2'b01, 0, 0, 0);
		send_operands(OP_LEN, 32'h7FFFFFFF, 0, 0, 2'b00, 0, 0, 0);
		send_operands(OP_NORM, 0, 0, 0, 2'b00, 0, 0, 0);
		send_operands(OP_NORM, 0, 0, 0, 2'b01, 0, 0, 0);
		send_operands(OP_NORM, 1, 0, 0, 2'b00, 0, 0, 0);
		send_operands(OP_NORM, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 2'b10, 0, 0, 0);
		send_operands(OP_NORM, 32'hFFFD0000, 32'h00040000, 0, 2'b11, 0, 0, 0);
		send_operands(OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 2'b00,
			32'h80000000, 32'h80000000, 32'h80000000);
		send_operands(OP_DOT, 32'h7FFFFFFF, 32'h80000000, 1, 2'b00,
			32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
		send_operands(OP_DOT, 32'hFFFFFFFF, 0, 0, 2'b01, 1, 0, 0);
		send_operands(OP_CROSS, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 2'b00,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_operands(OP_CROSS, 32'h00010000, 0, 0, 2'b00, 0, 32'h00010000, 0);
		send_operands(OP_CROSS, 32'hFFFFFFFF, 1, 0, 2'b00, 1, 1, 32'hFFFFFFFF);
		send_operands(3'd5, 32'h7FFFFFFF, 1, 2, 2'b01, 3, 4, 5);
		send_operands(3'd6, 32'h80000000, 1, 2, 2'b10, 3, 4, 5);
		send_operands(3'd7, 32'hFFFFFFFF, 1, 2, 2'b11, 3, 4, 5);

		drain_results();

		for (k = 0; k < N_RANDOM; k++) begin
			if (k % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
			if (k == N_RANDOM / 2) drain_results();
			op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_operands(op, rand_comp(), rand_comp(), rand_comp(), 2'($urandom()),
				rand_comp(), rand_comp(), rand_comp());
		end
		no_idle = 1'b0;

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("items per op: neg %0d len %0d norm %0d dot %0d cross %0d other %0d",
			op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
			op_count[5] + op_count[6] + op_count[7]);
		$display("%0d results checked, %0d mismatches", results_seen, errors);
		if (errors == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> vector3_alu.f
sv/v3a_pkg.sv
sv/v3a_front.sv
sv/v3a_root_cell.sv
sv/v3a_div_cell.sv
sv/vector3_alu.sv
tb/sv/tb_vector3_checker.sv
tb/sv/tb_top.sv
